>>> design/m3inv_pkg.sv
// Package of shared constants for the 3x3 matrix inverse and determinant unit.
package m3inv_pkg;

    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF = 16;

    typedef logic [3:0] elem_idx_t;

    // Cofactor n of the adjugate is el[i0]*el[i1] - el[i2]*el[i3].
    localparam elem_idx_t COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
        '{4'd5, 4'd6, 4'd8, 4'd3}, '{4'd8, 4'd0, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd5, 4'd0},
        '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
    };

endpackage

>>> design/matrix3x3_inverse_determinant_unit.sv
// Top level of the pipelined 3x3 matrix inverse and determinant unit.
//
// Channel  Direction  tdata fields (lowest bit up)                  tuser
// s_       in         a_r0c0 .. a_r2c2                              none
// m_       out        inv_r0c0 .. inv_r2c2, det_value               singular
//
// One matrix is accepted in every cycle while the spare entry is empty.
// The pipeline depth is set mainly by the restoring divider, one quotient bit per stage for each lane.
// Reset clears only the stage valid bits and the valid flags of the output register and spare entry.
// A stalled output is held with one spare entry; when that is full the whole pipeline waits.
module matrix3x3_inverse_determinant_unit #(
    parameter int ELEMENT_WIDTH = m3inv_pkg::ELEMENT_WIDTH_DEF,
    parameter int FRACTION_BITS = m3inv_pkg::FRACTION_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2
    input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // inv_r0c0 .. inv_r2c2 in row order, then det_value
    output logic [((10*ELEMENT_WIDTH+7)/8)*8-1:0]       m_tdata,
    // singular
    output logic [0:0]                                  m_tuser
);
    import m3inv_pkg::*;

    localparam int E    = ELEMENT_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int ODW  = ((10*E+7)/8)*8;
    localparam int PW   = 2*E;
    localparam int CW   = 2*E+1;
    localparam int LW   = 2*E+1;
    localparam int DW   = 3*E+3;
    localparam int NRW  = CW+2*F+1;
    localparam int UW   = ((NRW > DW+1) ? NRW : DW+1) + 1;
    localparam int XW   = UW+E;
    localparam int NS   = E+9;

    logic          en;
    logic [NS:1]   v_reg;

    logic signed [E-1:0]  el [9];
    logic signed [PW-1:0] pa1_reg [9];
    logic signed [PW-1:0] pb1_reg [9];
    logic signed [E-1:0]  top1_reg [3];
    logic signed [CW-1:0] cof2_reg [9];
    logic signed [E-1:0]  top2_reg [3];
    logic signed [LW-1:0] lo3_reg [3];
    logic signed [LW-1:0] hi3_reg [3];
    logic signed [CW-1:0] cof3_reg [9];
    logic signed [DW-1:0] t4_reg [3];
    logic signed [CW-1:0] cof4_reg [9];
    logic signed [DW-1:0] det5_reg;
    logic signed [CW-1:0] cof5_reg [9];
    logic [DW-1:0]        dabs6_reg;
    logic                 dneg6_reg;
    logic                 dzero6_reg;
    logic [CW-1:0]        cabs6_reg [9];
    logic                 cneg6_reg [9];
    logic [UW-1:0]        num7_reg [9];
    logic [UW-1:0]        den7_reg;
    logic [DW-1:0]        dq7_reg;
    logic                 neg7_reg [9];
    logic                 sing7_reg;
    logic                 dneg7_reg;

    logic [XW-1:0]        rem_st_reg [E+1][9];
    logic [E-1:0]         quo_st_reg [E+1][9];
    logic                 ovf_st_reg [E+1][9];
    logic                 neg_st_reg [E+1][9];
    logic [UW-1:0]        den_st_reg [E+1];
    logic [E-1:0]         deto_st_reg [E+1];
    logic                 sing_st_reg [E+1];

    logic [ODW-1:0]       fin_data_next;
    logic [ODW-1:0]       fin_data_reg;
    logic                 fin_sing_reg;
    logic [ODW-1:0]       out_data_reg;
    logic                 out_sing_reg;
    logic                 out_valid_reg;
    logic [ODW-1:0]       spare_data_reg;
    logic                 spare_sing_reg;
    logic                 spare_valid_reg;

    logic [DW-1:0]        dlim;
    logic [DW-1:0]        dsat;
    logic [E-1:0]         lim_e [9];
    logic [E-1:0]         qsat [9];
    logic [E-1:0]         qout [9];

    assign en       = ~spare_valid_reg;
    assign s_tready = en;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            el[k] = s_tdata[k*E +: E];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-1:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < 9; n++) begin
                pa1_reg[n] <= PW'(el[COF_IDX[n][0]]) * PW'(el[COF_IDX[n][1]]);
                pb1_reg[n] <= PW'(el[COF_IDX[n][2]]) * PW'(el[COF_IDX[n][3]]);
                cof2_reg[n] <= CW'(pa1_reg[n]) - CW'(pb1_reg[n]);
                cof3_reg[n] <= cof2_reg[n];
                cof4_reg[n] <= cof3_reg[n];
                cof5_reg[n] <= cof4_reg[n];
                cneg6_reg[n] <= cof5_reg[n][CW-1];
                cabs6_reg[n] <= cof5_reg[n][CW-1] ? $unsigned(-cof5_reg[n])
                                                  : $unsigned(cof5_reg[n]);
                num7_reg[n] <= (UW'(cabs6_reg[n]) << (2*F+1)) + UW'(dabs6_reg);
                neg7_reg[n] <= cneg6_reg[n] ^ dneg6_reg;
            end
            for (int k = 0; k < 3; k++) begin
                top1_reg[k] <= el[k];
                top2_reg[k] <= top1_reg[k];
                lo3_reg[k] <= LW'(top2_reg[k])
                              * $signed(LW'({1'b0, cof2_reg[3*k][E-1:0]}));
                hi3_reg[k] <= LW'(top2_reg[k]) * LW'($signed(cof2_reg[3*k][CW-1:E]));
                t4_reg[k] <= (DW'(hi3_reg[k]) <<< E) + DW'(lo3_reg[k]);
            end
            det5_reg   <= t4_reg[0] + t4_reg[1] + t4_reg[2];
            dneg6_reg  <= det5_reg[DW-1];
            dzero6_reg <= (det5_reg == '0);
            dabs6_reg  <= det5_reg[DW-1] ? $unsigned(-det5_reg) : $unsigned(det5_reg);
            den7_reg   <= UW'(dabs6_reg) << 1;
            dq7_reg    <= (dabs6_reg + (DW'(1) << (2*F-1))) >> (2*F);
            sing7_reg  <= dzero6_reg;
            dneg7_reg  <= dneg6_reg;
        end
    end

    always_comb begin
        dlim = (DW'(1) << (E-1)) - (dneg7_reg ? DW'(0) : DW'(1));
        dsat = (dq7_reg > dlim) ? dlim : dq7_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int n = 0; n < 9; n++) begin
                rem_st_reg[0][n] <= XW'(num7_reg[n]);
                quo_st_reg[0][n] <= '0;
                ovf_st_reg[0][n] <= XW'(num7_reg[n]) >= (XW'(den7_reg) << E);
                neg_st_reg[0][n] <= neg7_reg[n];
            end
            den_st_reg[0]  <= den7_reg;
            deto_st_reg[0] <= dneg7_reg ? E'(0) - dsat[E-1:0] : dsat[E-1:0];
            sing_st_reg[0] <= sing7_reg;
        end
    end

    for (genvar s = 1; s <= E; s++) begin : g_div_step
        localparam int J = E - s;
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int n = 0; n < 9; n++) begin
                    if (rem_st_reg[s-1][n] >= (XW'(den_st_reg[s-1]) << J)) begin
                        rem_st_reg[s][n] <= rem_st_reg[s-1][n] - (XW'(den_st_reg[s-1]) << J);
                        quo_st_reg[s][n] <= quo_st_reg[s-1][n] | (E'(1) << J);
                    end else begin
                        rem_st_reg[s][n] <= rem_st_reg[s-1][n];
                        quo_st_reg[s][n] <= quo_st_reg[s-1][n];
                    end
                    ovf_st_reg[s][n] <= ovf_st_reg[s-1][n];
                    neg_st_reg[s][n] <= neg_st_reg[s-1][n];
                end
                den_st_reg[s]  <= den_st_reg[s-1];
                deto_st_reg[s] <= deto_st_reg[s-1];
                sing_st_reg[s] <= sing_st_reg[s-1];
            end
        end
    end

    always_comb begin
        fin_data_next = '0;
        for (int n = 0; n < 9; n++) begin
            lim_e[n] = (E'(1) << (E-1)) - (neg_st_reg[E][n] ? E'(0) : E'(1));
            qsat[n]  = (ovf_st_reg[E][n] || (quo_st_reg[E][n] > lim_e[n])) ? lim_e[n]
                                                                          : quo_st_reg[E][n];
            qout[n]  = neg_st_reg[E][n] ? E'(0) - qsat[n] : qsat[n];
            fin_data_next[n*E +: E] = sing_st_reg[E] ? '0 : qout[n];
        end
        fin_data_next[9*E +: E] = sing_st_reg[E] ? '0 : deto_st_reg[E];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= fin_data_next;
            fin_sing_reg <= sing_st_reg[E];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (spare_valid_reg) begin
                out_data_reg    <= spare_data_reg;
                out_sing_reg    <= spare_sing_reg;
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end else begin
                out_data_reg  <= fin_data_reg;
                out_sing_reg  <= fin_sing_reg;
                out_valid_reg <= v_reg[NS];
            end
        end else if (en && v_reg[NS]) begin
            spare_data_reg  <= fin_data_reg;
            spare_sing_reg  <= fin_sing_reg;
            spare_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sing_reg;

    a_spare_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> out_valid_reg)
        else $error("Spare entry held while the output register is empty.");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[10*E-1:0] == '0))
        else $error("Singular transaction carries non-zero data.");

    a_stall_to_spare: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v_reg[NS] && m_tvalid && !m_tready) |=> spare_valid_reg)
        else $error("Result arriving during a stall was not kept in the spare entry.");

endmodule

>>> tb/matrix3x3_inverse_determinant_unit_checker.sv
// Checker that predicts and compares every result of the 3x3 matrix inverse unit.
`timescale 1ns / 1ps

module matrix3x3_inverse_determinant_unit_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [319:0] m_tdata,
    input  logic [0:0]   m_tuser,
    output int           fail_count,
    output int           pending_count,
    output int           checked_count,
    output int           singular_count
);
    import m3inv_pkg::*;

    localparam int EW = ELEMENT_WIDTH_DEF;
    localparam int FB = FRACTION_BITS_DEF;

    typedef struct packed {
        logic [10*EW-1:0] fields;
        logic             singular;
    } inverse_result_t;

    inverse_result_t expected_results[$];

    function automatic logic [EW-1:0] round_div_sat(logic signed [255:0] num,
                                                    logic signed [255:0] den);
        logic         neg;
        logic [255:0] an;
        logic [255:0] ad;
        logic [255:0] q;
        logic [255:0] lim;
        neg = num[255] ^ den[255];
        an  = num[255] ? -num : num;
        ad  = den[255] ? -den : den;
        q   = ((an << 1) + ad) / (ad << 1);
        lim = (256'd1 << (EW - 1)) - (neg ? 256'd0 : 256'd1);
        if (q > lim) begin
            q = lim;
        end
        if (neg) begin
            q = -q;
        end
        return q[EW-1:0];
    endfunction

    function automatic inverse_result_t invert_matrix(logic [9*EW-1:0] mat);
        logic signed [255:0] e [9];
        logic signed [255:0] det;
        logic signed [255:0] cof;
        inverse_result_t     r;
        for (int n = 0; n < 9; n++) begin
            e[n] = {{(256-EW){mat[n*EW+EW-1]}}, mat[n*EW+:EW]};
        end
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
            - e[0]*e[5]*e[7] - e[1]*e[3]*e[8] - e[2]*e[4]*e[6];
        r = '0;
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        for (int n = 0; n < 9; n++) begin
            cof = e[COF_IDX[n][0]] * e[COF_IDX[n][1]] - e[COF_IDX[n][2]] * e[COF_IDX[n][3]];
            cof = cof <<< (2 * FB);
            r.fields[n*EW+:EW] = round_div_sat(cof, det);
        end
        r.fields[9*EW+:EW] = round_div_sat(det, 256'd1 << (2 * FB));
        return r;
    endfunction

    assign pending_count = expected_results.size();

    initial begin
        fail_count     = 0;
        checked_count  = 0;
        singular_count = 0;
    end

    always @(posedge aclk) begin
        inverse_result_t want;
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(invert_matrix(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("Result transaction with no matrix outstanding");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (want.singular) singular_count++;
                for (int n = 0; n < 10; n++) begin
                    if (m_tdata[n*EW+:EW] !== want.fields[n*EW+:EW]) begin
                        $error("%s: expected %h, got %h",
                               n == 9 ? "det_value" : $sformatf("inv_r%0dc%0d", n / 3, n % 3),
                               want.fields[n*EW+:EW], m_tdata[n*EW+:EW]);
                        fail_count++;
                    end
                end
                if (m_tuser[0] !== want.singular) begin
                    $error("singular: expected %b, got %b", want.singular, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

endmodule

>>> tb/matrix3x3_inverse_determinant_unit_tb.sv
// Testbench top that drives matrices into the inverse unit and reports the verdict.
`timescale 1ns / 1ps

module matrix3x3_inverse_determinant_unit_tb;

    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 5000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;
    logic [0:0]   m_tuser;

    int fail_count;
    int pending_count;
    int checked_count;
    int singular_count;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_timer = 0;
    int directed_count = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    matrix3x3_inverse_determinant_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    matrix3x3_inverse_determinant_unit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .singular_count (singular_count)
    );

    // The receiver switches between always ready, light and heavy stalls, and long stalls.
    always @(negedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 120);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 8);
            end
            2: begin
                m_tready <= ($urandom_range(0, 9) < 3);
            end
            default: begin
                m_tready <= ($urandom_range(0, 39) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        int quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_matrix(input logic [287:0] mat);
        if (burst_left == 0) begin
            burst_left  = $urandom_range(1, 40);
            idle_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (idle_cycles > 0) begin
                s_tvalid <= 1'b0;
                repeat (idle_cycles) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    function automatic logic [287:0] build_matrix(input logic [31:0] e0, e1, e2, e3, e4,
                                                   e5, e6, e7, e8);
        return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
    endfunction

    function automatic logic [31:0] small_element();
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    function automatic logic [287:0] random_matrix(input int shape);
        logic [287:0] m;
        for (int n = 0; n < 9; n++) begin
            m[n*32+:32] = (shape == 1) ? $urandom() : small_element();
        end
        if (shape == 0) begin
            for (int n = 0; n < 3; n++) begin
                m[(4*n)*32+:32] = m[(4*n)*32+:32] + 32'h0006_0000;
            end
        end else if (shape == 2) begin
            m[6*32+:96] = m[0+:96];
        end else if (shape == 3) begin
            for (int n = 0; n < 3; n++) begin
                m[(3*n+2)*32+:32] = m[(3*n)*32+:32] << 1;
            end
        end else if (shape == 4) begin
            for (int n = 0; n < 9; n++) begin
                case ($urandom_range(0, 3))
                    0: m[n*32+:32] = 32'h7FFF_FFFF;
                    1: m[n*32+:32] = 32'h8000_0000;
                    2: m[n*32+:32] = 32'h0000_0001;
                    default: m[n*32+:32] = 32'h0000_0000;
                endcase
            end
        end
        return m;
    endfunction

    initial begin
        logic [287:0] directed [$];
        int           shape;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed.push_back('0);
        directed.push_back(build_matrix(32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000));
        directed.push_back(build_matrix(32'hFFFF_0000, 0, 0, 0, 32'hFFFF_0000, 0, 0, 0,
                                        32'hFFFF_0000));
        directed.push_back(build_matrix(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0,
                                        32'h7FFF_FFFF));
        directed.push_back(build_matrix(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0,
                                        32'h8000_0000));
        directed.push_back(build_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
        directed.push_back(build_matrix(32'h0000_0100, 0, 0, 0, 32'h0000_0100, 0, 0, 0,
                                        32'h0000_0100));
        directed.push_back({9{32'hFFFF_FFFF}});
        directed.push_back({9{32'h7FFF_FFFF}});
        directed.push_back({9{32'h8000_0000}});
        directed.push_back(build_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        directed.push_back(build_matrix(32'h2_0000, 32'h1_0000, 0, 32'h1_0000, 32'h3_0000,
                                        32'h1_0000, 0, 32'h1_0000, 32'h4_0000));
        directed.push_back(build_matrix(0, 32'h1_0000, 0, 32'h1_0000, 0, 0, 0, 0,
                                        32'h1_0000));
        directed.push_back(build_matrix(32'h3_0000, 0, 0, 0, 32'h3_0000, 0, 0, 0,
                                        32'h3_0000));
        directed.push_back(random_matrix(2));
        directed.push_back(random_matrix(3));
        directed.push_back(build_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F,
                                        32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
                                        32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678));
        foreach (directed[i]) begin
            send_matrix(directed[i]);
        end
        directed_count = directed.size();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            case ($urandom_range(0, 9))
                0, 1:    shape = 1;
                2:       shape = 2;
                3:       shape = 3;
                4:       shape = 4;
                5:       shape = 5;
                default: shape = 0;
            endcase
            send_matrix(random_matrix(shape));
        end

        drain_results();
        repeat (60) @(posedge aclk);
        $display("Drove %0d directed and %0d random matrices; %0d results checked, %0d singular.",
                 directed_count, RANDOM_ITEMS, checked_count, singular_count);
        $display("Both channels saw bursts, gaps and stalls, with one full drain mid-run.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/m3inv_pkg.sv
design/matrix3x3_inverse_determinant_unit.sv
tb/matrix3x3_inverse_determinant_unit_checker.sv
tb/matrix3x3_inverse_determinant_unit_tb.sv
